// ----- sv/sac_pkg.sv -----
package sac_pkg;

  localparam int COUNTER_BITS_DEF = 10;
  localparam int CHANGE_BITS_DEF  = 16;

  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_OUT_W = 16;

  localparam logic [1:0] RNG_HI  = 2'd0;
  localparam logic [1:0] RNG_MID = 2'd1;
  localparam logic [1:0] RNG_LO  = 2'd2;
  localparam logic [1:0] RNG_UNK = 2'd3;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_FORCE  = 2'd1;
  localparam logic [1:0] CMD_BOOT   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] FORCE_RELEASE = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_SAMPLES    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_SAMPLES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MUX_ADDR_HI     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MUX_ADDR_MID    = 2'd3;

  localparam logic [CFG_DATA_W-1:0] LOCK_SAMPLES_RST    = 10'd32;
  localparam logic [CFG_DATA_W-1:0] CONFIRM_SAMPLES_RST = 10'd8;
  localparam logic [1:0]            MUX_ADDR_HI_RST     = 2'd0;
  localparam logic [1:0]            MUX_ADDR_MID_RST    = 2'd1;

endpackage

// ----- sv/shunt_autorange_controller_top.sv -----
// Shunt autoranger: tracks the active shunt range (HI, MID, LO, unknown after reset)
// and drives the two bypass switches and the fine mux address.
// Input channel (in_valid / in_ready): one request per ADC sample period carrying cmd,
// the latched rising edges and the live latch levels, or a force / release, a boot or a no-op.
// Output channel (out_valid / out_ready): one result per request, showing the range,
// bypass drives, mux address, settling, changed, override and the switch count.
// Results are registered: a request's result is shown in the cycle after it is accepted.
// Throughput is one request per cycle unless the receiver stalls; the range state registers
// double as the result register, and the next request is taken in the cycle its result is taken.
// When the receiver stalls, the result holds and in_ready stays low until out_ready.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while the block is idle, as the block itself does not enforce it.
// Reset (rst, synchronous) sets the range to unknown, clears all counters and the
// override, and restores the configuration registers to their defaults.
module shunt_autorange_controller_top #(
  parameter int COUNTER_BITS = sac_pkg::COUNTER_BITS_DEF,
  parameter int CHANGE_BITS  = sac_pkg::CHANGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sac_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic                             edge_up_hi,
  input  logic                             edge_up_mid,
  input  logic                             level_hi,
  input  logic                             level_mid,
  input  logic [1:0]                       force_range,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       range,
  output logic                             bypass_51,
  output logic                             bypass_2,
  output logic [1:0]                       mux_addr,
  output logic                             mux_addr_valid,
  output logic                             settling,
  output logic                             changed,
  output logic                             override_on,
  output logic [sac_pkg::COUNT_OUT_W-1:0]  switch_count
);
  import sac_pkg::*;

  typedef struct packed {
    logic [1:0]              cur_range;
    logic [1:0]              prev_range;
    logic [COUNTER_BITS-1:0] lock_left;
    logic [COUNTER_BITS-1:0] confirm_level;
    logic                    down_pending;
    logic                    override_flag;
    logic [CHANGE_BITS-1:0]  change_total;
    logic [1:0]              mux_reg;
    logic                    mux_set;
  } st_t;

  localparam st_t ST_RST = '{
    cur_range:     RNG_UNK,
    prev_range:    RNG_UNK,
    lock_left:     '0,
    confirm_level: '0,
    down_pending:  1'b0,
    override_flag: 1'b0,
    change_total:  '0,
    mux_reg:       2'd0,
    mux_set:       1'b0
  };

  logic [CFG_DATA_W-1:0] lock_samples;
  logic [CFG_DATA_W-1:0] confirm_samples;
  logic [1:0]            mux_addr_hi;
  logic [1:0]            mux_addr_mid;

  st_t st;
  st_t st_next;
  logic in_accept;

  logic [COUNTER_BITS+CFG_DATA_W-1:0] lock_wide;
  logic [COUNTER_BITS+CFG_DATA_W-1:0] need_wide;
  logic [COUNTER_BITS-1:0]            lock_ld;
  logic [COUNTER_BITS-1:0]            need;
  logic [CHANGE_BITS+COUNT_OUT_W-1:0] total_wide;

  assign lock_wide = {{COUNTER_BITS{1'b0}}, lock_samples};
  assign need_wide = {{COUNTER_BITS{1'b0}}, confirm_samples};
  assign lock_ld   = lock_wide[COUNTER_BITS-1:0];
  assign need      = need_wide[COUNTER_BITS-1:0];

  function automatic st_t enter_range(st_t s, logic [1:0] r, logic [1:0] a_hi,
                                      logic [1:0] a_mid);
    st_t n;
    n = s;
    if (r != RNG_UNK) begin
      if (r == RNG_HI) begin
        n.mux_reg = a_hi;
        n.mux_set = 1'b1;
      end else if (r == RNG_MID) begin
        n.mux_reg = a_mid;
        n.mux_set = 1'b1;
      end
      if (r != s.cur_range) begin
        n.prev_range   = s.cur_range;
        n.cur_range    = r;
        n.change_total = s.change_total + 1'b1;
      end
    end
    return n;
  endfunction

  function automatic st_t arm_up(st_t s, logic [COUNTER_BITS-1:0] ld);
    st_t n;
    n = s;
    n.lock_left     = ld;
    n.down_pending  = 1'b0;
    n.confirm_level = '0;
    return n;
  endfunction

  always_comb begin
    logic have_pin;
    logic lvl;
    st_next  = st;
    have_pin = 1'b0;
    lvl      = 1'b0;
    unique case (cmd)
      CMD_SAMPLE: begin
        if (!st.override_flag) begin
          if (edge_up_hi && st_next.cur_range == RNG_HI) begin
            st_next = enter_range(st_next, RNG_MID, mux_addr_hi, mux_addr_mid);
            st_next = arm_up(st_next, lock_ld);
          end
          if (edge_up_mid && st_next.cur_range == RNG_MID) begin
            st_next = enter_range(st_next, RNG_LO, mux_addr_hi, mux_addr_mid);
            st_next = arm_up(st_next, lock_ld);
          end
          if (edge_up_mid && st_next.cur_range == RNG_HI) begin
            st_next = enter_range(st_next, RNG_MID, mux_addr_hi, mux_addr_mid);
            st_next = enter_range(st_next, RNG_LO, mux_addr_hi, mux_addr_mid);
            st_next = arm_up(st_next, lock_ld);
          end
          if (st_next.lock_left != '0) begin
            st_next.lock_left = st_next.lock_left - 1'b1;
          end else begin
            if (st_next.cur_range == RNG_MID) begin
              have_pin = 1'b1;
              lvl      = level_hi;
            end else if (st_next.cur_range == RNG_LO) begin
              have_pin = 1'b1;
              lvl      = level_mid;
            end
            if (have_pin) begin
              if (!lvl) begin
                st_next.down_pending = 1'b1;
                if (st_next.confirm_level < need) begin
                  st_next.confirm_level = st_next.confirm_level + 1'b1;
                end
              end else if (st_next.confirm_level != '0) begin
                st_next.confirm_level = st_next.confirm_level - 1'b1;
              end else begin
                st_next.down_pending = 1'b0;
              end
            end
            if (st_next.down_pending && st_next.confirm_level >= need) begin
              st_next.down_pending  = 1'b0;
              st_next.confirm_level = '0;
              st_next.lock_left     = lock_ld >> 1;
              if (st_next.cur_range == RNG_MID) begin
                st_next = enter_range(st_next, RNG_HI, mux_addr_hi, mux_addr_mid);
              end else if (st_next.cur_range == RNG_LO) begin
                st_next = enter_range(st_next, RNG_MID, mux_addr_hi, mux_addr_mid);
              end
            end
          end
        end
      end
      CMD_FORCE: begin
        if (force_range == FORCE_RELEASE) begin
          st_next.override_flag = 1'b0;
          st_next = arm_up(st_next, lock_ld);
        end else begin
          st_next = enter_range(st_next, force_range, mux_addr_hi, mux_addr_mid);
          st_next.override_flag = 1'b1;
          st_next.down_pending  = 1'b0;
          st_next.confirm_level = '0;
        end
      end
      CMD_BOOT: begin
        st_next = ST_RST;
        if (!level_hi && !level_mid) begin
          st_next = enter_range(st_next, RNG_HI, mux_addr_hi, mux_addr_mid);
        end else if (level_hi && !level_mid) begin
          st_next = enter_range(st_next, RNG_MID, mux_addr_hi, mux_addr_mid);
        end else begin
          st_next = enter_range(st_next, RNG_LO, mux_addr_hi, mux_addr_mid);
        end
      end
      CMD_NOP: begin
        st_next = st;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_samples    <= LOCK_SAMPLES_RST;
      confirm_samples <= CONFIRM_SAMPLES_RST;
      mux_addr_hi     <= MUX_ADDR_HI_RST;
      mux_addr_mid    <= MUX_ADDR_MID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCK_SAMPLES:    lock_samples    <= cfg_data;
        REG_CONFIRM_SAMPLES: confirm_samples <= cfg_data;
        REG_MUX_ADDR_HI:     mux_addr_hi     <= cfg_data[1:0];
        REG_MUX_ADDR_MID:    mux_addr_mid    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RST;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        st <= st_next;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields come straight from the state after the last request
  assign total_wide     = {{COUNT_OUT_W{1'b0}}, st.change_total};
  assign range          = st.cur_range;
  assign bypass_51      = (st.cur_range == RNG_MID) || (st.cur_range == RNG_LO);
  assign bypass_2       = (st.cur_range == RNG_LO);
  assign mux_addr       = st.mux_reg;
  assign mux_addr_valid = st.mux_set;
  assign settling       = (st.lock_left != '0);
  assign changed        = (st.cur_range != st.prev_range);
  assign override_on    = st.override_flag;
  assign switch_count   = total_wide[COUNT_OUT_W-1:0];

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(st))
    else $error("range state moved without a request");

  // a boot restarts the count, so only other requests are bounded
  a_at_most_two_changes: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd != CMD_BOOT) |=>
      (CHANGE_BITS'(st.change_total - $past(st.change_total)) <= 2))
    else $error("more than two range changes from one request");

  a_unknown_only_from_reset: assert property (@(posedge clk) disable iff (rst)
    (st.cur_range == RNG_UNK) |-> (st.change_total == '0 && !st.mux_set
                                   && st.prev_range == RNG_UNK))
    else $error("unknown range after a range was entered");

endmodule
